@@ src/abs_pkg.sv @@
// Shared widths, codes, the block descriptor type and the block length function.
package abs_pkg;

  // Fixed widths of the channel fields.
  localparam int SAMPLE_W = 12;
  localparam int DEV_W    = 15;
  localparam int SEL_W    = 2;

  // Internal widths. Samples never exceed 12 bits and blocks never exceed 64 samples.
  localparam int LEN_W  = 7;
  localparam int SUM_W  = 18;
  localparam int SQ_W   = 30;
  localparam int DIV_W  = 38;
  localparam int RAD_W  = 32;
  localparam int ROOT_W = 16;
  localparam int STEP_W = 5;

  // The divider retires two quotient bits per cycle; the root takes one bit per cycle.
  localparam int MEAN_STEPS  = SUM_W / 2;
  localparam int SCALE_STEPS = DIV_W / 2;
  localparam int ROOT_STEPS  = ROOT_W;

  // Block length selector codes. The unused code behaves like the largest length.
  localparam logic [SEL_W-1:0] SEL_16 = 2'd0;
  localparam logic [SEL_W-1:0] SEL_32 = 2'd1;
  localparam logic [SEL_W-1:0] SEL_64 = 2'd2;

  localparam int SHORT_BLOCK = 16;
  localparam int MID_BLOCK   = 32;
  localparam int LONG_BLOCK  = 64;

  // One finished block, handed from the front end to the statistics engine.
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0] maximum;
    logic [SAMPLE_W-1:0] last_sample;
    logic                bank;
    logic [LEN_W-1:0]    len;
  } blk_t;

  // Block length for a selector code, limited to the store size.
  function automatic logic [LEN_W-1:0] block_len(input logic [SEL_W-1:0] sel,
                                                 input int max_samples);
    int n;
    case (sel)
      SEL_16:  n = SHORT_BLOCK;
      SEL_32:  n = MID_BLOCK;
      SEL_64:  n = LONG_BLOCK;
      default: n = LONG_BLOCK;
    endcase
    if (n > max_samples) n = max_samples;
    return LEN_W'(n);
  endfunction

endpackage

@@ src/abs_ifs.sv @@
// Channel interfaces for samples, results and the block size register.
interface abs_sample_if import abs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface abs_result_if import abs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;
  logic [SAMPLE_W-1:0] minimum;
  logic [SAMPLE_W-1:0] maximum;
  logic [DEV_W-1:0]    deviation;
  logic [SAMPLE_W-1:0] last_sample;

  modport source (output valid, output average, output minimum, output maximum,
                  output deviation, output last_sample, input ready);
  modport sink (input valid, input average, input minimum, input maximum,
                input deviation, input last_sample, output ready);
endinterface

interface abs_cfg_if import abs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] size_select;

  modport source (output valid, output size_select, input ready);
  modport sink (input valid, input size_select, output ready);
endinterface

@@ src/adc_block_statistics.sv @@
// Once the last sample of a block is transferred, the engine computes its result unless it is
// still busy with an earlier block; a stalled result transfer also holds the result back.
// Throughput: samples are taken one per cycle while a bank is free; per block the engine runs
// the divider twice at two bits per cycle and the root at one bit per cycle, so its cost per
// sample falls as N grows from 16 to 32 and 64.
// Reset selects 16-sample blocks and clears accumulators, queue and result; not the store.
module adc_block_statistics import abs_pkg::*; #(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  abs_sample_if.sink   samples,
  abs_result_if.source results,
  abs_cfg_if.sink      cfg
);

  // Only the low bits of a sample take part; the store is that wide.
  localparam int KEEP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  // The store holds two banks so that one block can fill while the engine reads the other.
  localparam int ADDR_W = $clog2(MAX_SAMPLES) + 1;
  localparam int DEPTH  = 1 << ADDR_W;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEEP_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEEP_W-1:0] rd_data;
  logic              push_valid;
  logic              push_ready;
  blk_t              push_data;
  logic              pop_valid;
  logic              pop_ready;
  blk_t              pop_data;
  logic              release_bank;

  // The front end writes each sample into the current bank and keeps the running sum,
  // minimum and maximum. When a block is complete, its descriptor goes into the queue
  // and the front end moves to the other bank. It stalls only when both banks are held.
  abs_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .KEEP_W     (KEEP_W),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .cfg         (cfg),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data),
    .release_bank(release_bank)
  );

  // Short queue of finished blocks, so that front end and engine stall independently.
  abs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  abs_ram #(
    .WIDTH (KEEP_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // The engine divides the sum by the block length, reads the bank back to sum the squared
  // deviations from that truncated mean, scales by 256 and divides again, then takes the
  // square root. The bank is handed back to the front end once its last entry is read.
  // The result waits in an output register, so the engine may start the next block while
  // the previous transfer is still pending.
  abs_back #(
    .KEEP_W(KEEP_W),
    .ADDR_W(ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .release_bank(release_bank),
    .results     (results)
  );

endmodule

@@ src/abs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module abs_ram #(
  parameter int WIDTH  = 12,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

@@ src/abs_front.sv @@
// Front end: takes samples, stores them, keeps sum, minimum and maximum per block.
module abs_front import abs_pkg::*; #(
  parameter int MAX_SAMPLES = 64,
  parameter int KEEP_W      = 12,
  parameter int ADDR_W      = 7
) (
  input  logic              clk,
  input  logic              rst,
  abs_sample_if.sink        samples,
  abs_cfg_if.sink           cfg,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [KEEP_W-1:0] wr_data,
  output logic              push_valid,
  input  logic              push_ready,
  output blk_t              push_data,
  input  logic              release_bank
);

  localparam int IDX_W = ADDR_W - 1;
  localparam int BANKS = 2;
  localparam logic [SAMPLE_W-1:0] MIN_RESET = SAMPLE_W'((1 << KEEP_W) - 1);

  logic [SEL_W-1:0]    size_sel;
  logic [LEN_W-1:0]    fill;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic                bank;
  logic [1:0]          held;

  logic [SAMPLE_W-1:0] s;
  logic [LEN_W-1:0]    len;
  logic                take;
  logic                closing;
  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] max_next;

  always_comb begin
    s        = SAMPLE_W'(samples.sample[KEEP_W-1:0]);
    len      = block_len(size_sel, MAX_SAMPLES);
    // A bank counts as held from the push of its finished block until the engine has read it back.
    samples.ready = (held < 2'(BANKS)) && push_ready;
    take     = samples.valid && samples.ready;
    closing  = (fill + LEN_W'(1)) == len;
    sum_next = sum + SUM_W'(s);
    min_next = (s < run_min) ? s : run_min;
    max_next = (s > run_max) ? s : run_max;
    push_valid = take && closing;
    push_data  = '{sum: sum_next, minimum: min_next, maximum: max_next,
                   last_sample: s, bank: bank, len: len};
    wr_en   = take;
    wr_addr = {bank, IDX_W'(fill)};
    wr_data = s[KEEP_W-1:0];
    cfg.ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_sel <= SEL_16;
      fill     <= '0;
      sum      <= '0;
      run_min  <= MIN_RESET;
      run_max  <= '0;
      bank     <= 1'b0;
      held     <= '0;
    end else begin
      held <= held + 2'(push_valid && push_ready) - 2'(release_bank);
      if (cfg.valid) begin
        size_sel <= cfg.size_select;
        fill     <= '0;
        sum      <= '0;
        run_min  <= MIN_RESET;
        run_max  <= '0;
      end else if (take) begin
        if (closing) begin
          fill    <= '0;
          sum     <= '0;
          run_min <= MIN_RESET;
          run_max <= '0;
          bank    <= ~bank;
        end else begin
          fill    <= fill + LEN_W'(1);
          sum     <= sum_next;
          run_min <= min_next;
          run_max <= max_next;
        end
      end
    end
  end

endmodule

@@ src/abs_queue.sv @@
// Two-entry queue of finished block descriptors between front end and engine.
module abs_queue import abs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  blk_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output blk_t pop_data
);

  blk_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  always_comb begin
    push_ready = count != 2'd2;
    pop_valid  = count != 2'd0;
    pop_data   = entries[rd_ptr];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/abs_back.sv @@
// Statistics engine: mean division, squared-deviation pass, scaling and square root.
module abs_back import abs_pkg::*; #(
  parameter int KEEP_W = 12,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  blk_t              pop_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [KEEP_W-1:0] rd_data,
  output logic              release_bank,
  abs_result_if.source      results
);

  localparam int IDX_W = ADDR_W - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_PASS,
    ST_SCALE,
    ST_ROOT,
    ST_EMIT
  } state_t;

  state_t              state;
  logic [LEN_W-1:0]    len;
  logic                bank;
  logic [SAMPLE_W-1:0] blk_min;
  logic [SAMPLE_W-1:0] blk_max;
  logic [SAMPLE_W-1:0] blk_last;
  logic [DIV_W-1:0]    work;
  logic [LEN_W-1:0]    rem;
  logic [STEP_W-1:0]   steps;
  logic [SAMPLE_W-1:0] mean;
  logic [LEN_W-1:0]    rd_idx;
  logic                v1;
  logic                v2;
  logic [SAMPLE_W-1:0] diff;
  logic [SQ_W-1:0]     sq;
  logic [ROOT_W-1:0]   root;
  logic [ROOT_W+1:0]   srem;
  logic                res_valid;
  logic [SAMPLE_W-1:0] res_avg;
  logic [SAMPLE_W-1:0] res_min;
  logic [SAMPLE_W-1:0] res_max;
  logic [DEV_W-1:0]    res_dev;
  logic [SAMPLE_W-1:0] res_last;

  logic [LEN_W:0]      r1;
  logic [LEN_W:0]      r1s;
  logic [LEN_W:0]      r2;
  logic [LEN_W:0]      r2s;
  logic                q1;
  logic                q2;
  logic [DIV_W-1:0]    work_div;
  logic [LEN_W-1:0]    rem_div;
  logic [ROOT_W+3:0]   st;
  logic [ROOT_W+3:0]   trial;
  logic                root_ok;
  logic [ROOT_W+1:0]   srem_n;
  logic [ROOT_W-1:0]   root_n;
  logic [SAMPLE_W-1:0] rv;
  logic [SAMPLE_W-1:0] d;
  logic [2*SAMPLE_W-1:0] prod;
  logic                out_free;

  always_comb begin
    // Two restoring division steps per cycle; the divisor is the block length.
    r1  = {rem, work[DIV_W-1]};
    q1  = r1 >= {1'b0, len};
    r1s = q1 ? (r1 - {1'b0, len}) : r1;
    r2  = {r1s[LEN_W-1:0], work[DIV_W-2]};
    q2  = r2 >= {1'b0, len};
    r2s = q2 ? (r2 - {1'b0, len}) : r2;
    work_div = {work[DIV_W-3:0], q1, q2};
    rem_div  = r2s[LEN_W-1:0];

    // One bit of the integer square root per cycle.
    st      = {srem, work[RAD_W-1 -: 2]};
    trial   = (ROOT_W+4)'({root, 2'b01});
    root_ok = st >= trial;
    srem_n  = root_ok ? (ROOT_W+2)'(st - trial) : st[ROOT_W+1:0];
    root_n  = {root[ROOT_W-2:0], root_ok};

    rv   = SAMPLE_W'(rd_data);
    d    = (rv >= mean) ? (rv - mean) : (mean - rv);
    prod = diff * diff;

    rd_en        = (state == ST_PASS) && (rd_idx < len);
    rd_addr      = {bank, IDX_W'(rd_idx)};
    release_bank = rd_en && ((rd_idx + LEN_W'(1)) == len);
    pop_ready    = state == ST_IDLE;
    out_free     = !res_valid || results.ready;

    results.valid       = res_valid;
    results.average     = res_avg;
    results.minimum     = res_min;
    results.maximum     = res_max;
    results.deviation   = res_dev;
    results.last_sample = res_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      // A new result may replace the one being transferred in the same cycle.
      if ((state == ST_EMIT) && out_free) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            len      <= pop_data.len;
            bank     <= pop_data.bank;
            blk_min  <= pop_data.minimum;
            blk_max  <= pop_data.maximum;
            blk_last <= pop_data.last_sample;
            work     <= {pop_data.sum, (DIV_W-SUM_W)'(0)};
            rem      <= '0;
            steps    <= STEP_W'(MEAN_STEPS - 1);
            state    <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          work  <= work_div;
          rem   <= rem_div;
          steps <= steps - STEP_W'(1);
          if (steps == '0) begin
            mean   <= work_div[SAMPLE_W-1:0];
            rd_idx <= '0;
            v1     <= 1'b0;
            v2     <= 1'b0;
            sq     <= '0;
            state  <= ST_PASS;
          end
        end
        ST_PASS: begin
          if (rd_en) rd_idx <= rd_idx + LEN_W'(1);
          v1 <= rd_en;
          v2 <= v1;
          if (v1) diff <= d;
          if (v2) sq <= sq + SQ_W'(prod);
          if (!rd_en && !v1 && !v2) begin
            work  <= {sq, (DIV_W-SQ_W)'(0)};
            rem   <= '0;
            steps <= STEP_W'(SCALE_STEPS - 1);
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          work <= work_div;
          rem  <= rem_div;
          if (steps == '0) begin
            srem  <= '0;
            root  <= '0;
            steps <= STEP_W'(ROOT_STEPS - 1);
            state <= ST_ROOT;
          end else begin
            steps <= steps - STEP_W'(1);
          end
        end
        ST_ROOT: begin
          work  <= {work[DIV_W-3:0], 2'b00};
          srem  <= srem_n;
          root  <= root_n;
          steps <= steps - STEP_W'(1);
          if (steps == '0) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            res_avg   <= mean;
            res_min   <= blk_min;
            res_max   <= blk_max;
            res_dev   <= root[DEV_W-1:0];
            res_last  <= blk_last;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the ADC block statistics unit.
module tb import abs_pkg::*; ();

  // The store holds at most this many samples, matching the instance below.
  localparam int MAX_SAMPLES = 64;

  // Selector code that the package leaves unnamed. The block treats it as the longest length.
  localparam logic [SEL_W-1:0] SEL_SPARE = 2'd3;

  // Quiet cycles that settle() adds after the last pending summary. The longest
  // block is 64 samples, so this many quiet cycles guarantee the engine has finished.
  localparam int SETTLE_CYCLES = 150;

  // Generous ceiling on the run, far beyond the slowest legal run.
  localparam int RUN_LIMIT = 2_000_000;

  // Number of random samples to send after the directed part.
  localparam int RANDOM_SAMPLES = 1250;

  // Ways of filling a random block. Each one stresses a different part of the
  // statistics: full-range noise, a tight cluster with a tiny spread, samples
  // pinned to the rails for the widest spread, and a flat block with no spread.
  typedef enum logic [1:0] {
    SPREAD_UNIFORM,
    SPREAD_NARROW,
    SPREAD_RAILS,
    SPREAD_FLAT
  } spread_t;

  // One expected block summary, laid out like the result channel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] minimum;
    logic [SAMPLE_W-1:0] maximum;
    logic [DEV_W-1:0]    deviation;
    logic [SAMPLE_W-1:0] last_sample;
  } block_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  abs_sample_if samples_ch ();
  abs_result_if results_ch ();
  abs_cfg_if    size_ch ();

  adc_block_statistics #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .cfg     (size_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the accumulators of the block and is updated at
  // the same clock edges at which the block sees a transfer.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] block_mem [MAX_SAMPLES];
  bit   [SUM_W-1:0]    acc_sum;
  bit   [SAMPLE_W-1:0] acc_min;
  bit   [SAMPLE_W-1:0] acc_max;
  int unsigned         acc_fill;
  bit   [SEL_W-1:0]    cur_size_sel;

  // Summaries that have been predicted but not yet seen on the result channel.
  block_stats_t stats_due [$];

  int mismatches   = 0;
  int stats_seen   = 0;
  int samples_sent = 0;
  int size_writes  = 0;

  // When set, the respective side runs without idle cycles for a while.
  bit sender_steady = 1'b0;
  bit sink_steady   = 1'b0;

  // Block length for a selector code. The spare code falls back to the longest
  // block, and no length may exceed the size of the store.
  function automatic int unsigned samples_per_block(input bit [SEL_W-1:0] sel);
    int unsigned n;
    case (sel)
      SEL_16:  n = SHORT_BLOCK;
      SEL_32:  n = MID_BLOCK;
      default: n = LONG_BLOCK;
    endcase
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    return n;
  endfunction

  // Integer square root, one result bit per round, on a 64-bit radicand.
  function automatic bit [63:0] isqrt_q(input bit [63:0] radicand);
    bit [63:0] rem;
    bit [63:0] root;
    bit [63:0] probe;
    rem   = radicand;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic void restart_block();
    acc_sum  = '0;
    acc_min  = '1;
    acc_max  = '0;
    acc_fill = 0;
  endfunction

  // Any write of the size register, even with the value already held, throws
  // away the samples gathered so far.
  function automatic void apply_size(input bit [SEL_W-1:0] sel);
    cur_size_sel = sel;
    restart_block();
  endfunction

  // Folds one accepted sample into the running block. When the block is full,
  // the mean is truncated first and the spread is measured against that
  // truncated mean; the deviation is the integer root of 256 * S / N, which is
  // the standard deviation in Q11.4.
  function automatic void absorb_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned         n;
    int unsigned         i;
    bit [SAMPLE_W-1:0]   mean;
    bit [63:0]           diff;
    bit [63:0]           sq_sum;
    block_stats_t        summary;
    n = samples_per_block(cur_size_sel);
    if (acc_fill >= n) restart_block();
    block_mem[acc_fill] = s;
    acc_sum = acc_sum + s;
    if (s < acc_min) acc_min = s;
    if (s > acc_max) acc_max = s;
    acc_fill++;
    if (acc_fill < n) return;
    mean   = SAMPLE_W'(acc_sum / n);
    sq_sum = '0;
    for (i = 0; i < n; i++) begin
      diff   = (block_mem[i] >= mean) ? 64'(block_mem[i] - mean) : 64'(mean - block_mem[i]);
      sq_sum = sq_sum + diff * diff;
    end
    summary.average     = mean;
    summary.minimum     = acc_min;
    summary.maximum     = acc_max;
    summary.deviation   = DEV_W'(isqrt_q((sq_sum << 8) / n));
    summary.last_sample = block_mem[n - 1];
    stats_due.push_back(summary);
    restart_block();
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's own
  // updates of that edge take effect. A result is checked before a sample of
  // the same edge is folded in; the long latency keeps the two apart anyway.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (results_ch.valid && results_ch.ready) begin
        stats_seen++;
        if (stats_due.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with no block pending, average %0d", $time,
                   results_ch.average);
        end else begin
          block_stats_t want;
          want = stats_due.pop_front();
          compare_field("average", want.average, results_ch.average);
          compare_field("minimum", want.minimum, results_ch.minimum);
          compare_field("maximum", want.maximum, results_ch.maximum);
          compare_field("deviation", want.deviation, results_ch.deviation);
          compare_field("last_sample", want.last_sample, results_ch.last_sample);
        end
      end
      if (size_ch.valid && size_ch.ready) apply_size(size_ch.size_select);
      if (samples_ch.valid && samples_ch.ready) absorb_sample(samples_ch.sample);
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink. Before each transfer it may hold ready low for a random stall,
  // and now and then it switches into a stretch where ready never drops.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    results_ch.ready = 1'b0;
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 13);
      repeat (stall) begin
        @(negedge clk);
        results_ch.ready <= 1'b0;
      end
      @(negedge clk);
      results_ch.ready <= 1'b1;
      do @(posedge clk); while (!(results_ch.valid && results_ch.ready));
      if ($urandom_range(0, 7) == 0) sink_steady = !sink_steady;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one sample after a random idle gap and returns once it has been
  // transferred. Valid stays high afterwards until the next negative edge, where
  // either the next sample or an idle cycle replaces it, so it is never lowered
  // and raised within the same time step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      samples_ch.valid <= 1'b0;
    end
    @(negedge clk);
    samples_ch.valid  <= 1'b1;
    samples_ch.sample <= value;
    do @(posedge clk); while (!samples_ch.ready);
    samples_sent++;
    if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
  endtask

  // Stops offering samples, waits for every pending summary, then lets the
  // engine run out so that a dropped partial block cannot overlap a register write.
  task automatic settle();
    @(negedge clk);
    samples_ch.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the block size register. Only called while the block is idle.
  task automatic write_size(input logic [SEL_W-1:0] sel);
    @(negedge clk);
    size_ch.valid       <= 1'b1;
    size_ch.size_select <= sel;
    do @(posedge clk); while (!size_ch.ready);
    @(negedge clk);
    size_ch.valid <= 1'b0;
    size_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(input spread_t spread,
                                                      input logic [SAMPLE_W-1:0] center);
    int v;
    case (spread)
      SPREAD_NARROW: begin
        v = int'(center) + $urandom_range(0, 16) - 8;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      SPREAD_RAILS: begin
        // Mostly the exact rails, sometimes up to three codes away from them.
        v = ($urandom_range(0, 1) == 1) ? 4095 - $urandom_range(0, 1) * $urandom_range(0, 3)
                                         : $urandom_range(0, 1) * $urandom_range(0, 3);
      end
      SPREAD_FLAT: v = center;
      default:     v = $urandom_range(0, 4095);
    endcase
    return SAMPLE_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // After reset the block must already use 16-sample blocks. Samples alternate
  // between the two rails, which gives the widest possible spread, a mean that
  // truncates from 2047.5 and a last sample of zero.
  task automatic test_default_length();
    int k;
    for (k = 0; k < SHORT_BLOCK; k++)
      send_sample((k % 2 == 0) ? 12'hFFF : 12'h000);
    settle();
  endtask

  // A few samples followed by a write of the value already held: the partial
  // block must be thrown away, so the full block sent afterwards starts from scratch.
  task automatic test_write_drops_partial();
    int k;
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'h555);
    send_sample(12'hAAA);
    send_sample(12'h800);
    settle();
    write_size(SEL_16);
    for (k = 0; k < SHORT_BLOCK; k++) send_sample(SAMPLE_W'(k * 200 + 100));
    settle();
  endtask

  // Random phases. Each one sets a block size, sends a few full blocks with
  // random content and sometimes a trailing partial block, then settles. The
  // first phases walk through the longest, spare, middle and shortest codes.
  task automatic test_random_blocks();
    int                  phase;
    int                  sent;
    int                  blocks;
    int                  n;
    int                  k;
    int                  b;
    logic [SEL_W-1:0]    sel;
    spread_t             spread;
    logic [SAMPLE_W-1:0] center;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_SAMPLES) begin
      case (phase)
        0:       sel = SEL_64;
        1:       sel = SEL_SPARE;
        2:       sel = SEL_32;
        3:       sel = SEL_16;
        default: sel = SEL_W'($urandom_range(0, 3));
      endcase
      write_size(sel);
      n      = samples_per_block(sel);
      blocks = $urandom_range(1, 4);
      for (b = 0; b < blocks; b++) begin
        // Uniform noise is the most common fill; the other shapes hit the
        // corners of the spread calculation.
        spread = ($urandom_range(0, 2) == 0) ? spread_t'($urandom_range(0, 3)) : SPREAD_UNIFORM;
        center = $urandom_range(0, 4095);
        for (k = 0; k < n; k++) send_sample(draw_sample(spread, center));
        sent += n;
      end
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, n - 1);
        sent += k;
        repeat (k) send_sample(draw_sample(SPREAD_UNIFORM, '0));
      end
      settle();
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    samples_ch.valid    = 1'b0;
    samples_ch.sample   = '0;
    size_ch.valid       = 1'b0;
    size_ch.size_select = SEL_16;
    cur_size_sel        = SEL_16;
    restart_block();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_length();
    test_write_drops_partial();
    test_random_blocks();
    settle();

    $display("Run covered %0d samples in %0d checked block results with %0d size writes.",
             samples_sent, stats_seen, size_writes);
    $display("Mismatches found: %0d, summaries still pending: %0d.", mismatches,
             stats_due.size());
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a block that stalls a channel forever.
  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d summaries pending.", stats_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
src/abs_pkg.sv
src/abs_ifs.sv
src/abs_ram.sv
src/abs_front.sv
src/abs_queue.sv
src/abs_back.sv
src/adc_block_statistics.sv
bench/tb.sv
